>>> design/qlpr_pkg.sv
// Shared widths, pipeline record types and helpers for the quadratic root pipeline.
package qlpr_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Product, discriminant and square root widths
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int D_W    = 2 * WORD_BITS + 1;
  localparam int SQ_W   = (D_W + 1) / 2;
  localparam int DPAD_W = 2 * SQ_W;
  localparam int SREM_W = SQ_W + 2;

  // Root numerator and divider widths
  localparam int N_W    = SQ_W + 2;
  localparam int NMAG_W = SQ_W + 1;
  localparam int NUM_W  = NMAG_W + FRAC_BITS;
  localparam int DEN_W  = WORD_BITS + 1;
  localparam int DREM_W = DEN_W + 1;

  localparam logic [WORD_BITS-1:0] MAXPOS = {1'b0, {(WORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
    logic signed [WORD_BITS-1:0] lim;
    logic                        ok;
  } side_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [SQ_W-1:0]   root;
    logic [DPAD_W-1:0] dsh;
  } sq_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  q;
  } lane_t;

  typedef struct packed {
    logic [DEN_W-1:0]            den;
    logic                        neg1;
    logic                        neg2;
    logic signed [WORD_BITS-1:0] lim;
    logic                        ok;
  } dside_t;

  // Magnitude of a signed word, exact for the most negative value
  function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] r;
    r = x[WORD_BITS-1] ? (~x + 1'b1) : x;
    return r;
  endfunction

  // Saturate a quotient magnitude with its sign to the signed word range
  function automatic logic signed [WORD_BITS-1:0] sat_quot(input logic [NUM_W-1:0] q,
                                                           input logic neg);
    logic [NUM_W-1:0]     pos_lim;
    logic [NUM_W-1:0]     neg_lim;
    logic [WORD_BITS-1:0] m;
    logic signed [WORD_BITS-1:0] r;
    pos_lim = NUM_W'(MAXPOS);
    neg_lim = pos_lim + 1'b1;
    if (!neg) begin
      r = (q > pos_lim) ? MAXPOS : q[WORD_BITS-1:0];
    end else begin
      m = (q > neg_lim) ? neg_lim[WORD_BITS-1:0] : q[WORD_BITS-1:0];
      r = ~m + 1'b1;
    end
    return r;
  endfunction

endpackage

>>> design/qlpr_disc.sv
// Front stages: coefficient products, then the discriminant and its validity.
module qlpr_disc (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                vin,
  input  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_a,
  input  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_b,
  input  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_c,
  input  logic signed [qlpr_pkg::WORD_BITS-1:0] upper_limit,
  output logic                                vout,
  output qlpr_pkg::side_t                     side,
  output logic [qlpr_pkg::D_W-1:0]            disc
);

  logic                                  v1;
  logic signed [qlpr_pkg::WORD_BITS-1:0] a1;
  logic signed [qlpr_pkg::WORD_BITS-1:0] b1;
  logic signed [qlpr_pkg::WORD_BITS-1:0] lim1;
  logic [qlpr_pkg::PROD_W-1:0]           bb1;
  logic [qlpr_pkg::PROD_W-1:0]           ac1;
  logic                                  acneg1;

  logic [qlpr_pkg::WORD_BITS-1:0] mb;
  logic [qlpr_pkg::WORD_BITS-1:0] ma;
  logic [qlpr_pkg::WORD_BITS-1:0] mc;
  logic [qlpr_pkg::D_W-1:0]       bbw;
  logic [qlpr_pkg::D_W-1:0]       ac4;
  logic                           d_ok;
  logic [qlpr_pkg::D_W-1:0]       disc_next;

  assign mb = qlpr_pkg::mag(coef_b);
  assign ma = qlpr_pkg::mag(coef_a);
  assign mc = qlpr_pkg::mag(coef_c);

  // Take the two products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
    end
    if (en) begin
      a1     <= coef_a;
      b1     <= coef_b;
      lim1   <= upper_limit;
      bb1    <= qlpr_pkg::PROD_W'(mb) * qlpr_pkg::PROD_W'(mb);
      ac1    <= qlpr_pkg::PROD_W'(ma) * qlpr_pkg::PROD_W'(mc);
      acneg1 <= coef_a[qlpr_pkg::WORD_BITS-1] ^ coef_c[qlpr_pkg::WORD_BITS-1];
    end
  end

  // Form b*b - 4ac and flag a negative discriminant
  always_comb begin
    bbw  = qlpr_pkg::D_W'(bb1);
    ac4  = {ac1[qlpr_pkg::D_W-3:0], 2'b00};
    d_ok = acneg1 || (ac4 <= bbw);
    disc_next = acneg1 ? (bbw + ac4) : (bbw - ac4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v1;
    end
    if (en) begin
      side.a   <= a1;
      side.b   <= b1;
      side.lim <= lim1;
      side.ok  <= (a1 != '0) && d_ok;
      disc     <= disc_next;
    end
  end

endmodule

>>> design/qlpr_sqrt_step.sv
// One registered digit of the restoring integer square root.
module qlpr_sqrt_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  qlpr_pkg::sq_t   sin,
  input  qlpr_pkg::side_t side_in,
  output logic            vout,
  output qlpr_pkg::sq_t   sout,
  output qlpr_pkg::side_t side_out
);

  logic [qlpr_pkg::SREM_W-1:0] rem2;
  logic [qlpr_pkg::SREM_W-1:0] trial;
  logic                        take;

  // Bring down two bits and try the next root bit
  always_comb begin
    rem2  = {sin.rem[qlpr_pkg::SREM_W-3:0], sin.dsh[qlpr_pkg::DPAD_W-1 -: 2]};
    trial = {sin.root, 2'b01};
    take  = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      sout.rem  <= take ? (rem2 - trial) : rem2;
      sout.root <= {sin.root[qlpr_pkg::SQ_W-2:0], take};
      sout.dsh  <= {sin.dsh[qlpr_pkg::DPAD_W-3:0], 2'b00};
      side_out  <= side_in;
    end
  end

endmodule

>>> design/qlpr_div_step.sv
// One registered quotient bit of both restoring dividers, run side by side.
module qlpr_div_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  qlpr_pkg::lane_t  l1_in,
  input  qlpr_pkg::lane_t  l2_in,
  input  qlpr_pkg::dside_t side_in,
  output logic             vout,
  output qlpr_pkg::lane_t  l1_out,
  output qlpr_pkg::lane_t  l2_out,
  output qlpr_pkg::dside_t side_out
);

  logic [qlpr_pkg::DREM_W-1:0] r1;
  logic [qlpr_pkg::DREM_W-1:0] r2;
  logic [qlpr_pkg::DREM_W-1:0] dw;
  logic                        t1;
  logic                        t2;

  // Shift in the next numerator bit and subtract where it fits
  always_comb begin
    dw = qlpr_pkg::DREM_W'(side_in.den);
    r1 = {l1_in.rem[qlpr_pkg::DREM_W-2:0], l1_in.num[qlpr_pkg::NUM_W-1]};
    r2 = {l2_in.rem[qlpr_pkg::DREM_W-2:0], l2_in.num[qlpr_pkg::NUM_W-1]};
    t1 = r1 >= dw;
    t2 = r2 >= dw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      l1_out.rem <= t1 ? (r1 - dw) : r1;
      l1_out.num <= {l1_in.num[qlpr_pkg::NUM_W-2:0], 1'b0};
      l1_out.q   <= {l1_in.q[qlpr_pkg::NUM_W-2:0], t1};
      l2_out.rem <= t2 ? (r2 - dw) : r2;
      l2_out.num <= {l2_in.num[qlpr_pkg::NUM_W-2:0], 1'b0};
      l2_out.q   <= {l2_in.q[qlpr_pkg::NUM_W-2:0], t2};
      side_out   <= side_in;
    end
  end

endmodule

>>> design/quadratic_lowest_positive_root.sv
// Register stages: 2 product/discriminant, 33 root digits, 1 numerator, 50 quotient, 1 out.
// Throughput: one transaction per cycle; every stage advances while the output is free or taken.
// A stalled output holds the whole pipeline, one digit or quotient bit per register stage.
// Reset: synchronous, active high; clears all stage valid bits, data registers are not reset.
module quadratic_lowest_positive_root (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_a,
  input  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_b,
  input  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_c,
  input  logic signed [qlpr_pkg::WORD_BITS-1:0] upper_limit,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  found,
  output logic [qlpr_pkg::WORD_BITS-2:0]        root_value
);

  logic en;

  logic                     dv;
  qlpr_pkg::side_t          dside;
  logic [qlpr_pkg::D_W-1:0] disc;

  logic             sv [qlpr_pkg::SQ_W+1];
  qlpr_pkg::sq_t    sq [qlpr_pkg::SQ_W+1];
  qlpr_pkg::side_t  ss [qlpr_pkg::SQ_W+1];

  logic             qv  [qlpr_pkg::NUM_W+1];
  qlpr_pkg::lane_t  ql1 [qlpr_pkg::NUM_W+1];
  qlpr_pkg::lane_t  ql2 [qlpr_pkg::NUM_W+1];
  qlpr_pkg::dside_t qs  [qlpr_pkg::NUM_W+1];

  logic signed [qlpr_pkg::N_W-1:0]   nb;
  logic signed [qlpr_pkg::N_W-1:0]   n1;
  logic signed [qlpr_pkg::N_W-1:0]   n2;
  logic [qlpr_pkg::N_W-1:0]          m1;
  logic [qlpr_pkg::N_W-1:0]          m2;
  logic [qlpr_pkg::WORD_BITS-1:0]    ma;

  logic signed [qlpr_pkg::WORD_BITS-1:0] x1;
  logic signed [qlpr_pkg::WORD_BITS-1:0] x2;
  logic signed [qlpr_pkg::WORD_BITS-1:0] lo;
  logic signed [qlpr_pkg::WORD_BITS-1:0] hi;
  logic                                  found_next;
  logic signed [qlpr_pkg::WORD_BITS-1:0] root_next;

  // Advance everything unless a result waits untaken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  qlpr_disc u_disc (
    .clk, .rst, .en,
    .vin (in_valid),
    .coef_a, .coef_b, .coef_c, .upper_limit,
    .vout (dv),
    .side (dside),
    .disc (disc)
  );

  // Square root chain, most significant digit first
  assign sv[0]       = dv;
  assign sq[0].rem   = '0;
  assign sq[0].root  = '0;
  assign sq[0].dsh   = qlpr_pkg::DPAD_W'(disc);
  assign ss[0]       = dside;

  for (genvar g = 0; g < qlpr_pkg::SQ_W; g++) begin : g_sqrt
    qlpr_sqrt_step u_step (
      .clk, .rst, .en,
      .vin (sv[g]), .sin (sq[g]), .side_in (ss[g]),
      .vout (sv[g+1]), .sout (sq[g+1]), .side_out (ss[g+1])
    );
  end

  // Form both numerators and the divisor
  always_comb begin
    nb = -qlpr_pkg::N_W'(ss[qlpr_pkg::SQ_W].b);
    n1 = nb - $signed(qlpr_pkg::N_W'(sq[qlpr_pkg::SQ_W].root));
    n2 = nb + $signed(qlpr_pkg::N_W'(sq[qlpr_pkg::SQ_W].root));
    m1 = n1[qlpr_pkg::N_W-1] ? -n1 : n1;
    m2 = n2[qlpr_pkg::N_W-1] ? -n2 : n2;
    ma = qlpr_pkg::mag(ss[qlpr_pkg::SQ_W].a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (en) begin
      qv[0] <= sv[qlpr_pkg::SQ_W];
    end
    if (en) begin
      ql1[0].rem <= '0;
      ql1[0].num <= {m1[qlpr_pkg::NMAG_W-1:0], {qlpr_pkg::FRAC_BITS{1'b0}}};
      ql1[0].q   <= '0;
      ql2[0].rem <= '0;
      ql2[0].num <= {m2[qlpr_pkg::NMAG_W-1:0], {qlpr_pkg::FRAC_BITS{1'b0}}};
      ql2[0].q   <= '0;
      qs[0].den  <= {ma, 1'b0};
      qs[0].neg1 <= n1[qlpr_pkg::N_W-1] ^ ss[qlpr_pkg::SQ_W].a[qlpr_pkg::WORD_BITS-1];
      qs[0].neg2 <= n2[qlpr_pkg::N_W-1] ^ ss[qlpr_pkg::SQ_W].a[qlpr_pkg::WORD_BITS-1];
      qs[0].lim  <= ss[qlpr_pkg::SQ_W].lim;
      qs[0].ok   <= ss[qlpr_pkg::SQ_W].ok;
    end
  end

  // Quotient chain, one bit per stage for both roots
  for (genvar g = 0; g < qlpr_pkg::NUM_W; g++) begin : g_div
    qlpr_div_step u_step (
      .clk, .rst, .en,
      .vin (qv[g]), .l1_in (ql1[g]), .l2_in (ql2[g]), .side_in (qs[g]),
      .vout (qv[g+1]), .l1_out (ql1[g+1]), .l2_out (ql2[g+1]), .side_out (qs[g+1])
    );
  end

  // Saturate, order and pick the lowest root inside the window
  always_comb begin
    x1 = qlpr_pkg::sat_quot(ql1[qlpr_pkg::NUM_W].q, qs[qlpr_pkg::NUM_W].neg1);
    x2 = qlpr_pkg::sat_quot(ql2[qlpr_pkg::NUM_W].q, qs[qlpr_pkg::NUM_W].neg2);
    lo = (x1 > x2) ? x2 : x1;
    hi = (x1 > x2) ? x1 : x2;
    found_next = 1'b0;
    root_next  = '0;
    if (qs[qlpr_pkg::NUM_W].ok) begin
      if (lo > 0 && lo < qs[qlpr_pkg::NUM_W].lim) begin
        found_next = 1'b1;
        root_next  = lo;
      end else if (hi > 0 && hi < qs[qlpr_pkg::NUM_W].lim) begin
        found_next = 1'b1;
        root_next  = hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= qv[qlpr_pkg::NUM_W];
    end
    if (en) begin
      found      <= found_next;
      root_value <= root_next[qlpr_pkg::WORD_BITS-2:0];
    end
  end

  // A transaction without a root carries a zero value
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> root_value == '0)
    else $error("root value not zero without a root");

  // An accepted root is strictly positive
  a_root_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> root_value != '0)
    else $error("zero root reported as found");

  // Nothing leaves the pipeline straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the smallest positive quadratic root pipeline.
module tb_top;

  localparam int LATENCY    = 87;
  localparam int IDLE_PCT   = 22;
  localparam int RAND_ITEMS = 1620;

  typedef struct packed {
    logic        fnd;
    logic [30:0] root;
  } root_res_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  in_valid;
  logic                                  in_ready;
  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_a;
  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_b;
  logic signed [qlpr_pkg::WORD_BITS-1:0] coef_c;
  logic signed [qlpr_pkg::WORD_BITS-1:0] upper_limit;
  logic                                  out_valid;
  logic                                  out_ready;
  logic                                  found;
  logic [qlpr_pkg::WORD_BITS-2:0]        root_value;

  root_res_t roots_due[$];
  int        n_sent;
  int        n_found;
  int        n_checked;
  int        n_fail;
  bit        calm;

  quadratic_lowest_positive_root i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .coef_c      (coef_c),
    .upper_limit (upper_limit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .root_value  (root_value)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // (n << 16) / den, truncated toward zero and saturated to the signed word
  function automatic longint quot_sat(input longint n, input longint den);
    logic [127:0] num;
    logic [127:0] q;
    logic [63:0]  dm;
    bit           neg;
    neg = (n < 0) != (den < 0);
    num = 128'(n < 0 ? -n : n) << qlpr_pkg::FRAC_BITS;
    dm  = den < 0 ? -den : den;
    q   = num / 128'(dm);
    if (!neg) return (q > 128'h7fff_ffff) ? 64'sh7fff_ffff : longint'(q[63:0]);
    if (q > 128'h8000_0000) q = 128'h8000_0000;
    return -longint'(q[63:0]);
  endfunction

  // Lowest root strictly inside (0, lim), or not found
  function automatic root_res_t solve_root(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic signed [31:0] c,
                                           input logic signed [31:0] lim);
    root_res_t    r;
    logic [127:0] bb;
    logic [127:0] ac4;
    logic [127:0] d;
    logic [63:0]  s;
    logic [63:0]  t;
    longint       x1;
    longint       x2;
    longint       sw;
    longint       bl;
    r  = '0;
    bl = b;
    if (a == 0) return r;
    bb  = 128'(bl < 0 ? -bl : bl) * 128'(bl < 0 ? -bl : bl);
    ac4 = (128'(qlpr_pkg::mag(a)) * 128'(qlpr_pkg::mag(c))) << 2;
    if ((a < 0) != (c < 0)) d = bb + ac4;
    else if (ac4 > bb) return r;
    else d = bb - ac4;
    s = '0;
    for (int i = 63; i >= 0; i--) begin
      t = s | (64'd1 << i);
      if (128'(t) * 128'(t) <= d) s = t;
    end
    x1 = quot_sat(-bl - longint'(s), 2 * longint'(a));
    x2 = quot_sat(-bl + longint'(s), 2 * longint'(a));
    if (x1 > x2) begin
      sw = x1;
      x1 = x2;
      x2 = sw;
    end
    if (x1 > 0 && x1 < lim) begin
      r.fnd  = 1'b1;
      r.root = x1[30:0];
    end else if (x2 > 0 && x2 < lim) begin
      r.fnd  = 1'b1;
      r.root = x2[30:0];
    end
    return r;
  endfunction

  // Offer one transaction, holding it until accepted
  task automatic send_item(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] lim);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    coef_a      <= a;
    coef_b      <= b;
    coef_c      <= c;
    upper_limit <= lim;
    do @(posedge clk); while (!in_ready);
    roots_due.push_back(solve_root(a, b, c, lim));
    n_sent++;
  endtask

  // Hold the input until every expected result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Build a quadratic with chosen roots so that many items have a root
  task automatic send_shaped();
    longint a;
    longint r1;
    longint r2;
    longint b;
    longint c;
    longint lim;
    a   = longint'($urandom_range(1, 1 << 19)) * ($urandom_range(1) ? 1 : -1);
    r1  = longint'($urandom_range(0, 1 << 21)) - (1 << 19);
    r2  = longint'($urandom_range(0, 1 << 21)) - (1 << 19);
    b   = -((a * (r1 + r2)) >>> qlpr_pkg::FRAC_BITS);
    c   = (((a * r1) >>> qlpr_pkg::FRAC_BITS) * r2) >>> qlpr_pkg::FRAC_BITS;
    lim = $urandom_range(3) == 0 ? longint'($urandom)
                                 : longint'($urandom_range(0, 1 << 22)) - (1 << 18);
    send_item(a[31:0], b[31:0], c[31:0], lim[31:0]);
  endtask

  task automatic test_directed();
    send_item(32'h0, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff);  // a zero
    send_item(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h7fff_ffff);  // negative D
    send_item(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 32'h0010_0000);
    send_item(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 32'h0001_8000);
    send_item(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 32'h0);  // limit zero
    send_item(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 32'h8000_0000);
    send_item(32'h0001_0000, 32'hfffc_0000, 32'h0004_0000, 32'h7fff_ffff);  // double root
    send_item(32'hffff_0000, 32'h0003_0000, 32'hfffe_0000, 32'h7fff_ffff);  // a negative
    send_item(32'h0000_0001, 32'h8000_0000, 32'h0, 32'h7fff_ffff);  // saturation
    send_item(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff);
    send_item(32'h0001_0000, 32'h0, 32'h0, 32'h7fff_ffff);  // root at zero
    send_item(32'h0002_0000, 32'hfff8_0000, 32'h0006_0000, 32'h0001_0000);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 600 && i < 800);
      if ($urandom_range(99) < 70) send_shaped();
      else send_item($urandom, $urandom, $urandom, $urandom);
    end
    calm = 1'b0;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    root_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        n_checked++;
        if (roots_due.size() == 0) begin
          $error("result with none pending: found=%0d root=%0h", found, root_value);
          n_fail++;
        end else begin
          want = roots_due.pop_front();
          if (want.fnd) n_found++;
          if (found !== want.fnd) begin
            $error("found: expected %0d actual %0d", want.fnd, found);
            n_fail++;
          end
          if (root_value !== want.root) begin
            $error("root_value: expected %0h actual %0h", want.root, root_value);
            n_fail++;
          end
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    coef_a      = '0;
    coef_b      = '0;
    coef_c      = '0;
    upper_limit = '0;
    calm        = 1'b0;
    n_sent      = 0;
    n_found     = 0;
    n_checked   = 0;
    n_fail      = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain_results();
    test_random_mix();
    drain_results();
    if (roots_due.size() != 0) begin
      $error("%0d results never arrived", roots_due.size());
      n_fail++;
    end
    $display("Sent %0d transactions, checked %0d results, %0d with a root found.",
             n_sent, n_checked, n_found);
    if (n_fail == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
design/qlpr_pkg.sv
design/qlpr_disc.sv
design/qlpr_sqrt_step.sv
design/qlpr_div_step.sv
design/quadratic_lowest_positive_root.sv
dv/tb_top.sv
